### hdl/matrix3x3_inverse_assert.svh
// Assertion macros for the checker file of the 3x3 matrix inverse.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define MINV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MINV_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/minv_pkg.sv
// Shared constants, types and index tables of the 3x3 matrix inverse.
`timescale 1ns / 1ps
package minv_pkg;
    localparam int FIELD_W       = 32;
    localparam int N_ELEM        = 9;
    localparam int N_ROW         = 3;
    localparam int ELEM_W_DEF    = 32;
    localparam int FRAC_BITS_DEF = 16;
    // Register stages from the input to the divider lanes.
    localparam int FRONT_LAT     = 7;

    // Adjugate element k (row-major index r*3+c) is m[A]*m[B] - m[C]*m[D].
    localparam int COF_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_C [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_D [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic dneg;
        logic sing;
    } t_det_flags;
endpackage

### hdl/minv_front.sv
// Cofactor and determinant pipeline of the 3x3 matrix inverse.
`timescale 1ns / 1ps
module minv_front import minv_pkg::*; #(
    parameter int W  = ELEM_W_DEF,
    parameter int F  = FRAC_BITS_DEF,
    parameter int DW = 3 * ELEM_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic [N_ELEM*FIELD_W-1:0]   i_data,
    output logic signed [2*W:0]         o_cof [N_ELEM],
    output logic [DW-1:0]               o_den,
    output t_det_flags                  o_flags
);
    localparam int CW = 2 * W + 1;
    localparam int TW = 3 * W + 1;

    logic signed [W-1:0]    r_m1 [N_ELEM];
    logic signed [W-1:0]    r_m2 [N_ROW];
    logic signed [W-1:0]    r_m3 [N_ROW];
    logic signed [2*W-1:0]  r_pa [N_ELEM];
    logic signed [2*W-1:0]  r_pb [N_ELEM];
    logic signed [CW-1:0]   r_c3 [N_ELEM];
    logic signed [CW-1:0]   r_c4 [N_ELEM];
    logic signed [CW-1:0]   r_c5 [N_ELEM];
    logic signed [CW-1:0]   r_c6 [N_ELEM];
    logic signed [CW-1:0]   r_c7 [N_ELEM];
    logic signed [CW-1:0]   r_plo [N_ROW];
    logic signed [CW-1:0]   r_phi [N_ROW];
    logic signed [TW-1:0]   r_term [N_ROW];
    logic signed [TW-1:0]   r_det;
    logic [DW-1:0]          r_den;
    t_det_flags             r_flags;

    logic signed [CW-1:0]   n_plo [N_ROW];
    logic signed [CW-1:0]   n_phi [N_ROW];
    logic signed [TW-1:0]   det_abs;

    always_comb begin
        for (int j = 0; j < N_ROW; j++) begin
            n_plo[j] = r_m3[j] * $signed({1'b0, r_c3[3*j][W-1:0]});
            n_phi[j] = r_m3[j] * $signed(r_c3[3*j][2*W:W]);
        end
        det_abs = r_det[TW-1] ? -r_det : r_det;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_m1[i] <= $signed(i_data[FIELD_W*i +: W]);
                r_pa[i] <= r_m1[COF_A[i]] * r_m1[COF_B[i]];
                r_pb[i] <= r_m1[COF_C[i]] * r_m1[COF_D[i]];
                r_c3[i] <= CW'(r_pa[i]) - CW'(r_pb[i]);
                r_c4[i] <= r_c3[i];
                r_c5[i] <= r_c4[i];
                r_c6[i] <= r_c5[i];
                r_c7[i] <= r_c6[i];
            end
            for (int j = 0; j < N_ROW; j++) begin
                r_m2[j]   <= r_m1[j];
                r_m3[j]   <= r_m2[j];
                r_plo[j]  <= n_plo[j];
                r_phi[j]  <= n_phi[j];
                r_term[j] <= (TW'(r_phi[j]) <<< W) + TW'(r_plo[j]);
            end
            r_det <= r_term[0] + r_term[1] + r_term[2];
            // A zero determinant is replaced by one in the 3F fraction format.
            if (r_det == '0) begin
                r_den <= DW'(1) << (3 * F);
            end else begin
                r_den <= DW'($unsigned(det_abs[TW-2:0]));
            end
            r_flags.sing <= (r_det == '0);
            r_flags.dneg <= r_det[TW-1];
        end
    end

    assign o_cof   = r_c7;
    assign o_den   = r_den;
    assign o_flags = r_flags;
endmodule

### hdl/minv_div_lane.sv
// One pipelined restoring divider lane with truncation and saturation.
`timescale 1ns / 1ps
module minv_div_lane import minv_pkg::*; #(
    parameter int W  = ELEM_W_DEF,
    parameter int F  = FRAC_BITS_DEF,
    parameter int DW = 3 * ELEM_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_ce,
    input  logic signed [2*W:0] i_cof,
    input  logic [DW-1:0]       i_den,
    input  logic                i_dneg,
    output logic [FIELD_W-1:0]  o_q
);
    localparam int NA = 2 * W + 2 * F;
    localparam int NB = DW + W - 1;
    localparam int NW = (NA > NB) ? NA : NB;

    logic [NW-1:0]          r_rem [0:W];
    logic [DW-1:0]          r_dn  [0:W];
    logic                   r_neg [0:W];
    logic                   r_ovf [1:W];
    logic [W-2:0]           r_q   [1:W];
    logic [FIELD_W-1:0]     r_out;

    logic signed [2*W:0]    cof_abs;
    logic [W-1:0]           qv;
    logic signed [W-1:0]    res;

    always_comb begin
        cof_abs = i_cof[2*W] ? -i_cof : i_cof;
        qv      = {1'b0, r_q[W]};
        if (r_ovf[W]) begin
            res = r_neg[W] ? $signed({1'b1, {(W-1){1'b0}}}) : $signed({1'b0, {(W-1){1'b1}}});
        end else begin
            res = r_neg[W] ? -$signed(qv) : $signed(qv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= NW'($unsigned(cof_abs[2*W-1:0])) << (2 * F);
            r_dn[0]  <= i_den;
            r_neg[0] <= i_cof[2*W] ^ i_dneg;
            // A quotient of 2^(W-1) or more saturates; the remaining steps are ignored.
            r_rem[1] <= r_rem[0];
            r_dn[1]  <= r_dn[0];
            r_neg[1] <= r_neg[0];
            r_ovf[1] <= (r_rem[0] >= (NW'(r_dn[0]) << (W - 1)));
            r_q[1]   <= '0;
            r_out    <= FIELD_W'(res);
        end
    end

    for (genvar j = 2; j <= W; j++) begin : g_step
        logic [NW-1:0] dsh;
        logic          ge;
        always_comb begin
            dsh = NW'(r_dn[j-1]) << (W - j);
            ge  = (r_rem[j-1] >= dsh);
        end
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[j] <= ge ? (r_rem[j-1] - dsh) : r_rem[j-1];
                r_dn[j]  <= r_dn[j-1];
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
                r_q[j]   <= {r_q[j-1][W-3:0], ge};
            end
        end
    end

    assign o_q = r_out;
endmodule

### hdl/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse by adjugate over determinant.
//
// The slave channel takes one matrix per item: nine signed Q16.16 elements,
// row-major, element r*3+c in tdata bits [32*(r*3+c) +: 32]. The master channel
// returns the inverse in the same layout, with tuser[0] set when the
// determinant was zero and the adjugate itself was returned.
// The block is a single pipeline: seven stages form the cofactors and the
// determinant with 32x32 and 32x33 multipliers, then nine divider lanes, one
// per element, each resolve one quotient bit a stage.
// An item is accepted every cycle as long as the receiver takes results.
// When the receiver holds tready low with a result waiting, the whole
// pipeline holds and s_axis tready drops; bubbles in the pipeline are not
// squeezed out. Reset empties the pipeline; payload registers are not reset.
// Elements wider than ELEMENT_WIDTH use only their low bits; results are
// sign-extended from ELEMENT_WIDTH to 32 bits.
`timescale 1ns / 1ps
module matrix3x3_inverse import minv_pkg::*; #(
    parameter int ELEMENT_WIDTH = ELEM_W_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
    input  logic [N_ELEM*FIELD_W-1:0]   i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2, inv_r2c0,
    // inv_r2c1, inv_r2c2
    output logic [N_ELEM*FIELD_W-1:0]   o_m_axis_tdata,
    // was_singular
    output logic [0:0]                  o_m_axis_tuser
);
    localparam int W     = ELEMENT_WIDTH;
    localparam int DW    = (3 * W > 3 * FRAC_BITS + 1) ? 3 * W : 3 * FRAC_BITS + 1;
    localparam int LLAT  = W + 2;
    localparam int DEPTH = FRONT_LAT + LLAT;

    logic                   ce;
    logic [DEPTH-1:0]       r_vld;
    logic [DEPTH-1:0]       n_vld;
    logic [LLAT-1:0]        r_sing;
    logic signed [2*W:0]    cof [N_ELEM];
    logic [DW-1:0]          den;
    t_det_flags             flags;
    logic [FIELD_W-1:0]     lane_q [N_ELEM];

    assign ce = !r_vld[DEPTH-1] || i_m_axis_tready;

    always_comb begin
        n_vld = {r_vld[DEPTH-2:0], i_s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sing <= {r_sing[LLAT-2:0], flags.sing};
        end
    end

    minv_front #(.W(W), .F(FRAC_BITS), .DW(DW)) u_front (
        .i_clk   (i_clk),
        .i_ce    (ce),
        .i_data  (i_s_axis_tdata),
        .o_cof   (cof),
        .o_den   (den),
        .o_flags (flags)
    );

    for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
        minv_div_lane #(.W(W), .F(FRAC_BITS), .DW(DW)) u_lane (
            .i_clk  (i_clk),
            .i_ce   (ce),
            .i_cof  (cof[i]),
            .i_den  (den),
            .i_dneg (flags.dneg),
            .o_q    (lane_q[i])
        );
        assign o_m_axis_tdata[FIELD_W*i +: FIELD_W] = lane_q[i];
    end

    assign o_s_axis_tready   = ce;
    assign o_m_axis_tvalid   = r_vld[DEPTH-1];
    assign o_m_axis_tuser[0] = r_sing[LLAT-1];
endmodule

### hdl/minv_checker.sv
// Port-level checker of the 3x3 matrix inverse and its bind.
`timescale 1ns / 1ps
`include "matrix3x3_inverse_assert.svh"
module minv_checker import minv_pkg::*; (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [N_ELEM*FIELD_W-1:0]   o_m_axis_tdata,
    input logic [0:0]                  o_m_axis_tuser
);
    // The pipeline moves exactly when its output slot is free or being taken.
    `MINV_ASSERT(a_ready_follows_out, o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready), "input ready does not follow the output slot")
    `MINV_ASSERT_RST(a_reset_empties, !i_rst_n |=> !o_m_axis_tvalid, "result shown after reset")
    `MINV_ASSERT(a_stall_holds, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")
    // An input item offered without ready must still be offered at the next edge.
    `MINV_ASSERT(a_in_valid_holds, i_s_axis_tvalid && !o_s_axis_tready |=> i_s_axis_tvalid, "input item withdrawn while waiting")
endmodule

bind matrix3x3_inverse minv_checker u_minv_checker (.*);
